[rtl/sdm_pkg.sv]
// ----------------------------------------------------------------------------
// sdm_pkg: shared types and constants for the two-voice sine DDS mixer
// Field widths, register indexes and the shared multiplier request type.
// ----------------------------------------------------------------------------
package sdm_pkg;

    localparam int SAMPLE_W  = 15;
    localparam int VOLUME_W  = 12;
    localparam int STEP_W    = 26;
    localparam int LEVEL_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int MUL_B_W   = 12;
    localparam int MUL_P_W   = SAMPLE_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] REG_A_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B_STEP = 2'd1;

    localparam logic [MUL_B_W-1:0] SCALE_FIVE = 12'd5;

    typedef enum logic [1:0] {
        MSH_0,
        MSH_12,
        MSH_16
    } mul_shift_t;

    typedef struct packed {
        logic                en;
        logic [SAMPLE_W-1:0] a;
        logic [MUL_B_W-1:0]  b;
        mul_shift_t          sh;
    } mul_req_t;

endpackage

[rtl/two_voice_sine_dds_mixer.sv]
// ----------------------------------------------------------------------------
// two_voice_sine_dds_mixer: two-voice sine DDS mixed to a PWM level
// A sequencer walks one phase adder, one ROM read port and one multiplier
// through eight steps per item: PH_A, PH_B, RD_B, AVG, MUL_P, MUL_V, MUL_5 and
// EMIT, which waits while the output stalls. A new input is taken only in
// idle. A nonzero step write is reduced modulo TABLE_DEPTH << 16.
// Reset clears phases, steps and the output register.
// ----------------------------------------------------------------------------
module two_voice_sine_dds_mixer #(
    parameter int TABLE_DEPTH  = 1000,
    parameter int LEVEL_PERIOD = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sdm_pkg::VOLUME_W-1:0]  volume,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sdm_pkg::LEVEL_W-1:0]   pwm_level,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdm_pkg::STEP_W-1:0]    cfg_data
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int PHASE_W = ADDR_W + sdm_pkg::FRAC_W;
    localparam int SUM_W   = ((PHASE_W > sdm_pkg::STEP_W) ? PHASE_W : sdm_pkg::STEP_W) + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(TABLE_DEPTH) << sdm_pkg::FRAC_W;
    localparam logic [sdm_pkg::SAMPLE_W-1:0] PERIOD_S = sdm_pkg::SAMPLE_W'(LEVEL_PERIOD);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PH_A,
        ST_PH_B,
        ST_RD_B,
        ST_AVG,
        ST_MUL_P,
        ST_MUL_V,
        ST_MUL_5,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic [PHASE_W-1:0]            phase_a_reg, phase_b_reg;
    logic [PHASE_W-1:0]            step_a_reg, step_b_reg;
    logic [sdm_pkg::STEP_W-1:0]    rem_reg;
    logic                          tgt_b_reg;
    logic [sdm_pkg::VOLUME_W-1:0]  vol_reg;
    logic [sdm_pkg::SAMPLE_W-1:0]  acc_reg;
    logic                          out_valid_reg;
    logic [sdm_pkg::LEVEL_W-1:0]   pwm_level_reg;

    logic [SUM_W-1:0]              add_a, add_b, add_sum, add_wrap;
    logic                          add_ge;
    logic [ADDR_W-1:0]             rom_addr;
    logic [sdm_pkg::SAMPLE_W-1:0]  rom_q;
    sdm_pkg::mul_req_t             mul_req;
    logic [sdm_pkg::SAMPLE_W-1:0]  mul_q;
    logic [sdm_pkg::SAMPLE_W-1:0]  sat_level;
    logic                          in_take, cfg_take, out_take, out_free;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign in_take   = in_valid && !in_stall;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // shared phase adder with single wrap
    always_comb
    begin
        case (state_reg)
            ST_PH_A:
            begin
                add_a = SUM_W'(phase_a_reg);
                add_b = SUM_W'(step_a_reg);
            end
            ST_PH_B:
            begin
                add_a = SUM_W'(phase_b_reg);
                add_b = SUM_W'(step_b_reg);
            end
            ST_REDUCE:
            begin
                add_a = SUM_W'(rem_reg);
                add_b = '0;
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum  = add_a + add_b;
    assign add_ge   = (add_sum >= LIMIT);
    assign add_wrap = add_ge ? (add_sum - LIMIT) : add_sum;

    assign rom_addr = (state_reg == ST_PH_B) ? phase_a_reg[PHASE_W-1:sdm_pkg::FRAC_W]
                                             : phase_b_reg[PHASE_W-1:sdm_pkg::FRAC_W];

    sdm_rom #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    always_comb
    begin
        mul_req.en = 1'b0;
        mul_req.a  = mul_q;
        mul_req.b  = sdm_pkg::SCALE_FIVE;
        mul_req.sh = sdm_pkg::MSH_0;
        case (state_reg)
            ST_MUL_P:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = acc_reg;
                mul_req.b  = sdm_pkg::MUL_B_W'(LEVEL_PERIOD);
                mul_req.sh = sdm_pkg::MSH_16;
            end
            ST_MUL_V:
            begin
                mul_req.en = 1'b1;
                mul_req.b  = vol_reg;
                mul_req.sh = sdm_pkg::MSH_12;
            end
            ST_MUL_5:
            begin
                mul_req.en = 1'b1;
            end
            default:
            begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    sdm_mul u_mul (
        .clk (clk),
        .req (mul_req),
        .q   (mul_q)
    );

    assign sat_level = (mul_q > PERIOD_S) ? PERIOD_S : mul_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_a_reg   <= '0;
            phase_b_reg   <= '0;
            step_a_reg    <= '0;
            step_b_reg    <= '0;
            rem_reg       <= '0;
            tgt_b_reg     <= 1'b0;
            vol_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            pwm_level_reg <= '0;
        end
        else
        begin
            if (out_take && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_take)
                    begin
                        if (cfg_index == sdm_pkg::REG_A_STEP || cfg_index == sdm_pkg::REG_B_STEP)
                        begin
                            tgt_b_reg <= (cfg_index == sdm_pkg::REG_B_STEP);
                            rem_reg   <= cfg_data;
                            if (cfg_data == '0)
                            begin
                                if (cfg_index == sdm_pkg::REG_B_STEP)
                                begin
                                    step_b_reg  <= '0;
                                    phase_b_reg <= '0;
                                end
                                else
                                begin
                                    step_a_reg  <= '0;
                                    phase_a_reg <= '0;
                                end
                            end
                            else
                            begin
                                state_reg <= ST_REDUCE;
                            end
                        end
                    end
                    else if (in_take)
                    begin
                        vol_reg   <= volume;
                        state_reg <= ST_PH_A;
                    end
                end
                ST_REDUCE:
                begin
                    if (add_ge)
                    begin
                        rem_reg <= sdm_pkg::STEP_W'(add_wrap);
                    end
                    else
                    begin
                        if (tgt_b_reg)
                        begin
                            step_b_reg <= PHASE_W'(rem_reg);
                        end
                        else
                        begin
                            step_a_reg <= PHASE_W'(rem_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PH_A:
                begin
                    phase_a_reg <= PHASE_W'(add_wrap);
                    state_reg   <= ST_PH_B;
                end
                ST_PH_B:
                begin
                    phase_b_reg <= PHASE_W'(add_wrap);
                    state_reg   <= ST_RD_B;
                end
                ST_RD_B:
                begin
                    acc_reg   <= rom_q;
                    state_reg <= ST_AVG;
                end
                ST_AVG:
                begin
                    acc_reg   <= sdm_pkg::SAMPLE_W'(({1'b0, acc_reg} + {1'b0, rom_q}) >> 1);
                    state_reg <= ST_MUL_P;
                end
                ST_MUL_P:
                begin
                    state_reg <= ST_MUL_V;
                end
                ST_MUL_V:
                begin
                    state_reg <= ST_MUL_5;
                end
                ST_MUL_5:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pwm_level_reg <= sat_level[sdm_pkg::LEVEL_W-1:0];
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign pwm_level = pwm_level_reg;

endmodule

[rtl/sdm_rom.sv]
// ----------------------------------------------------------------------------
// sdm_rom: sine wavetable with registered read
// Entry i = floor(16383*sin(2*pi*i/N) + 16384), built at elaboration with
// exact Q60 integer arithmetic.
// ----------------------------------------------------------------------------
module sdm_rom #(
    parameter int TABLE_DEPTH = 1000,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                         clk,
    input  logic [ADDR_W-1:0]            addr,
    output logic [sdm_pkg::SAMPLE_W-1:0] q
);

    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
    localparam logic [63:0] M30     = 64'h3FFF_FFFF;
    localparam logic [63:0] M32     = 64'hFFFF_FFFF;
    localparam logic [63:0] DEPTH64 = 64'(TABLE_DEPTH);

    typedef logic [sdm_pkg::SAMPLE_W-1:0] rom_array_t [TABLE_DEPTH];

    // restoring long division, table build only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo, rem;
        int          m;
        quo = '0;
        rem = '0;
        for (m = 63; m >= 0; m--)
        begin
            rem = {rem[62:0], num[m]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[m] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = a & M32;
        ah  = a >> 32;
        bl  = b & M32;
        bh  = b >> 32;
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + (lh & M32) + (hl & M32);
        lo  = (ll & M32) | (mid << 32);
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 4) | (lo >> 60);
    endfunction

    // Machin: pi = 16*atan(1/5) - 4*atan(1/239)
    function automatic logic [63:0] pi_q60();
        logic [63:0] at [2];
        logic [63:0] k, k2, p, sum, n;
        logic        done;
        int          j, m;
        for (j = 0; j < 2; j++)
        begin
            k    = (j == 0) ? 64'd5 : 64'd239;
            p    = div_u64(ONE_Q60, k);
            sum  = p;
            k2   = k * k;
            n    = 64'd1;
            done = 1'b0;
            for (m = 0; m < 64; m++)
            begin
                if (!done)
                begin
                    p = div_u64(p, k2);
                    if (p == 64'd0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        if (n[0])
                        begin
                            sum = sum - div_u64(p, 64'd2 * n + 64'd1);
                        end
                        else
                        begin
                            sum = sum + div_u64(p, 64'd2 * n + 64'd1);
                        end
                        n = n + 64'd1;
                    end
                end
            end
            at[j] = sum;
        end
        return 64'd16 * at[0] - 64'd4 * at[1];
    endfunction

    function automatic logic [63:0] sin_q60(input logic [63:0] x);
        logic [63:0] x2, term, sum, k;
        logic        done;
        int          m;
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        k    = 64'd1;
        done = 1'b0;
        for (m = 0; m < 40; m++)
        begin
            if (!done)
            begin
                term = div_u64(mul_q60(term, x2), (64'd2 * k) * (64'd2 * k + 64'd1));
                if (term == 64'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    if (k[0])
                    begin
                        sum = sum - term;
                    end
                    else
                    begin
                        sum = sum + term;
                    end
                    k = k + 64'd1;
                end
            end
        end
        return (sum > ONE_Q60) ? ONE_Q60 : sum;
    endfunction

    function automatic logic [63:0] rom_entry(input logic [63:0] i, input logic [63:0] pi);
        logic [63:0] two_pi, half_pi, x, s, a, b, t;
        logic        neg;
        two_pi  = 64'd2 * pi;
        half_pi = pi / 64'd2;
        if (i == 64'd0 || 64'd2 * i == DEPTH64)
        begin
            return 64'd16384;
        end
        if (64'd4 * i == DEPTH64)
        begin
            return 64'd32767;
        end
        if (64'd4 * i == 64'd3 * DEPTH64)
        begin
            return 64'd1;
        end
        x   = (two_pi / DEPTH64) * i + ((two_pi % DEPTH64) * i) / DEPTH64;
        neg = (64'd2 * i > DEPTH64);
        if (neg)
        begin
            x = (x > pi) ? x - pi : 64'd0;
        end
        if (x > half_pi)
        begin
            x = (pi > x) ? pi - x : 64'd0;
        end
        s = sin_q60(x);
        a = 64'd16383 * (s >> 30);
        b = 64'd16383 * (s & M30);
        if (!neg)
        begin
            t = a + (b >> 30);
            return 64'd16384 + (t >> 30);
        end
        t = a + ((b + M30) >> 30);
        return 64'd16384 - ((t + M30) >> 30);
    endfunction

    function automatic rom_array_t build_rom();
        rom_array_t  rom;
        logic [63:0] pi;
        int          i;
        pi = pi_q60();
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            rom[i] = sdm_pkg::SAMPLE_W'(rom_entry(64'(i), pi));
        end
        return rom;
    endfunction

    localparam rom_array_t SINE_ROM = build_rom();

    logic [sdm_pkg::SAMPLE_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= SINE_ROM[addr];
    end

    assign q = q_reg;

endmodule

[rtl/sdm_mul.sv]
// ----------------------------------------------------------------------------
// sdm_mul: shared multiply-and-shift unit
// One registered 15x12 multiplier with a selectable right shift.
// ----------------------------------------------------------------------------
module sdm_mul (
    input  logic                         clk,
    input  sdm_pkg::mul_req_t            req,
    output logic [sdm_pkg::SAMPLE_W-1:0] q
);

    logic [sdm_pkg::MUL_P_W-1:0]  prod;
    logic [sdm_pkg::SAMPLE_W-1:0] shifted;
    logic [sdm_pkg::SAMPLE_W-1:0] q_reg;

    assign prod = sdm_pkg::MUL_P_W'(req.a) * sdm_pkg::MUL_P_W'(req.b);

    always_comb
    begin
        case (req.sh)
            sdm_pkg::MSH_16: shifted = sdm_pkg::SAMPLE_W'(prod >> 16);
            sdm_pkg::MSH_12: shifted = sdm_pkg::SAMPLE_W'(prod >> 12);
            sdm_pkg::MSH_0:  shifted = sdm_pkg::SAMPLE_W'(prod);
            default:         shifted = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            q_reg <= shifted;
        end
    end

    assign q = q_reg;

endmodule

[rtl/sdm_checker.sv]
// ----------------------------------------------------------------------------
// sdm_checker: port-level checks for the two-voice sine DDS mixer
// Watches handshakes and the output range; bound to the top level.
// ----------------------------------------------------------------------------
module sdm_checker #(
    parameter int LEVEL_PERIOD = 50
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [sdm_pkg::VOLUME_W-1:0]  volume,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [sdm_pkg::LEVEL_W-1:0]   pwm_level,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [sdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [sdm_pkg::STEP_W-1:0]    cfg_data
);

    logic unused_ok;
    assign unused_ok = ^{volume, cfg_index, cfg_data};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pwm_level))
        else $error("output transaction dropped or changed while stalled");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (LEVEL_PERIOD > 63) || (pwm_level <= LEVEL_PERIOD))
        else $error("pwm_level above period");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !cfg_ready)
        else $error("block not busy after accepting a transaction");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> in_stall)
        else $error("input accepted together with a config write");

endmodule

bind two_voice_sine_dds_mixer sdm_checker #(.LEVEL_PERIOD(LEVEL_PERIOD)) u_sdm_checker (.*);
